[hdl/pmct_pkg.sv]
// Shared types and constants for the PS/2 mouse cursor tracker.
// No dependencies; imported by every module of the block.
`default_nettype none

package pmct_pkg;

   // Fixed field widths
   localparam int BYTE_W     = 8;
   localparam int CSR_DATA_W = 12;
   localparam int CSR_IDX_W  = 1;
   localparam int CURSOR_W   = 12;
   localparam int MOVE_W     = 9;

   // Default coordinate width
   localparam int COORD_BITS_DEFAULT = 12;

   // Header byte bit positions
   localparam int HDR_SYNC_BIT  = 3;
   localparam int HDR_XSIGN_BIT = 4;
   localparam int HDR_YSIGN_BIT = 5;

   // Reset values
   localparam logic [CSR_DATA_W-1:0] MAX_X_RESET = 12'd319;
   localparam logic [CSR_DATA_W-1:0] MAX_Y_RESET = 12'd199;
   localparam int POS_X_RESET = 160;
   localparam int POS_Y_RESET = 100;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_X = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_Y = 1'b1;

   // Packet byte phase
   typedef enum logic [1:0] {
      PHASE_HDR = 2'd0,
      PHASE_X   = 2'd1,
      PHASE_Y   = 2'd2
   } phase_type;

   // One decoded movement, 9-bit two's complement each
   typedef struct packed {
      logic signed [MOVE_W-1:0] dx;
      logic signed [MOVE_W-1:0] dy;
   } move_type;

endpackage

`default_nettype wire

[hdl/pmct_packet_asm.sv]
// Packet assembler: gathers header, X and Y bytes into one movement beat.
// Depends on pmct_pkg for the phase enum and the movement struct.
`default_nettype none

module pmct_packet_asm
   import pmct_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [BYTE_W-1:0] req_rx_byte,
   output logic                   mv_valid,
   input  wire logic              mv_ready,
   output move_type               mv
);

   phase_type phase_ff, phase_in;
   logic [BYTE_W-1:0] header_ff;
   logic [BYTE_W-1:0] x_byte_ff;
   logic              mv_valid_ff, mv_valid_in;
   move_type          mv_ff, mv_in;
   logic              accept;
   logic              mv_free;
   logic              hdr_load, x_load, mv_load;

   // Movement slot frees up when empty or drained this cycle
   assign mv_free   = !mv_valid_ff || mv_ready;
   assign req_ready = (phase_ff != PHASE_Y) || mv_free;
   assign accept    = req_valid && req_ready;

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PHASE_X: begin
            if (accept) phase_in = PHASE_Y;
         end
         PHASE_Y: begin
            if (accept) phase_in = PHASE_HDR;
         end
         PHASE_HDR: begin
            if (accept) phase_in = req_rx_byte[HDR_SYNC_BIT] ? PHASE_X : PHASE_HDR;
         end
         default: begin
            if (accept) phase_in = req_rx_byte[HDR_SYNC_BIT] ? PHASE_X : PHASE_HDR;
         end
      endcase
   end

   // Load strobes per phase
   always_comb begin
      hdr_load = 1'b0;
      x_load   = 1'b0;
      mv_load  = 1'b0;
      unique case (phase_ff)
         PHASE_X: begin
            x_load = accept;
         end
         PHASE_Y: begin
            mv_load = accept;
         end
         PHASE_HDR: begin
            hdr_load = accept && req_rx_byte[HDR_SYNC_BIT];
         end
         default: begin
            hdr_load = accept && req_rx_byte[HDR_SYNC_BIT];
         end
      endcase
   end

   // Form the signed movements from sign bits and data bytes
   always_comb begin
      mv_in.dx = $signed({header_ff[HDR_XSIGN_BIT], x_byte_ff});
      mv_in.dy = $signed({header_ff[HDR_YSIGN_BIT], req_rx_byte});
   end

   // Hold the beat until the cursor stage takes it
   assign mv_valid_in = mv_load || (mv_valid_ff && !mv_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PHASE_HDR;
         mv_valid_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         mv_valid_ff <= mv_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (hdr_load) header_ff <= req_rx_byte;
      if (x_load)   x_byte_ff <= req_rx_byte;
      if (mv_load)  mv_ff     <= mv_in;
   end

   assign mv_valid = mv_valid_ff;
   assign mv       = mv_ff;

endmodule

`default_nettype wire

[hdl/pmct_cursor_upd.sv]
// Cursor update: applies one movement beat and clamps to the limits.
// Depends on pmct_pkg; the position registers double as the result register.
`default_nettype none

module pmct_cursor_upd
   import pmct_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  mv_valid,
   output logic                       mv_ready,
   input  wire move_type              mv,
   input  wire logic [CSR_DATA_W-1:0] max_x,
   input  wire logic [CSR_DATA_W-1:0] max_y,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [CURSOR_W-1:0]        rsp_cursor_x,
   output logic [CURSOR_W-1:0]        rsp_cursor_y
);

   localparam int SUM_W = COORD_BITS + 2;
   localparam logic [COORD_BITS-1:0] RESET_X = COORD_BITS'(POS_X_RESET);
   localparam logic [COORD_BITS-1:0] RESET_Y = COORD_BITS'(POS_Y_RESET);

   logic [COORD_BITS-1:0]   pos_x_ff, pos_x_in;
   logic [COORD_BITS-1:0]   pos_y_ff, pos_y_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [SUM_W-1:0] sum_x, sum_y;
   logic signed [SUM_W-1:0] lim_x, lim_y;
   logic                    advance;

   // Take a beat once the previous result is gone
   assign mv_ready = !rsp_valid_ff || rsp_ready;
   assign advance  = mv_valid && mv_ready;

   // Add X, subtract Y
   always_comb begin
      sum_x = $signed({2'b00, pos_x_ff}) + $signed({{(SUM_W-MOVE_W){mv.dx[MOVE_W-1]}}, mv.dx});
      sum_y = $signed({2'b00, pos_y_ff}) - $signed({{(SUM_W-MOVE_W){mv.dy[MOVE_W-1]}}, mv.dy});
      lim_x = $signed({2'b00, COORD_BITS'(max_x)});
      lim_y = $signed({2'b00, COORD_BITS'(max_y)});
   end

   // Clamp each coordinate to 0..limit
   always_comb begin
      if (sum_x[SUM_W-1])   pos_x_in = '0;
      else if (sum_x > lim_x) pos_x_in = lim_x[COORD_BITS-1:0];
      else                  pos_x_in = sum_x[COORD_BITS-1:0];

      if (sum_y[SUM_W-1])   pos_y_in = '0;
      else if (sum_y > lim_y) pos_y_in = lim_y[COORD_BITS-1:0];
      else                  pos_y_in = sum_y[COORD_BITS-1:0];
   end

   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff     <= RESET_X;
         pos_y_ff     <= RESET_Y;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            pos_x_ff <= pos_x_in;
            pos_y_ff <= pos_y_in;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_cursor_x = CURSOR_W'(pos_x_ff);
   assign rsp_cursor_y = CURSOR_W'(pos_y_ff);

endmodule

`default_nettype wire

[hdl/ps2_mouse_cursor_tracker_unit.sv]
// Top level of the PS/2 mouse cursor tracker: limit registers and the two stages.
// Depends on pmct_pkg, pmct_packet_asm and pmct_cursor_upd.
//
//   Channel  Direction  Handshake            Payload
//   req_     in         req_valid/req_ready  req_rx_byte[7:0]
//   rsp_     out        rsp_valid/rsp_ready  rsp_cursor_x[11:0], rsp_cursor_y[11:0]
//   csr_     in         csr_valid/csr_ready  csr_index[0], csr_data[11:0]
//
// One byte is taken per cycle, save for a Y byte that waits on a stalled result. A result
// for the third byte of a packet passes from the movement register through the
// add and clamp into the position register, which also drives rsp_.
// Synchronous reset puts the limits at 319/199 and the cursor at 160/100.
// A stalled result holds the movement register; header and X bytes keep
// flowing, and only a Y byte waits while both registers are full.
`default_nettype none

module ps2_mouse_cursor_tracker_unit
   import pmct_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [BYTE_W-1:0]     req_rx_byte,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [CURSOR_W-1:0]        rsp_cursor_x,
   output logic [CURSOR_W-1:0]        rsp_cursor_y,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   logic [CSR_DATA_W-1:0] max_x_ff, max_x_in;
   logic [CSR_DATA_W-1:0] max_y_ff, max_y_in;
   logic                  csr_write;
   logic                  mv_valid;
   logic                  mv_ready;
   move_type              mv;

   // Limit registers take every write beat
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      max_x_in = max_x_ff;
      max_y_in = max_y_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_MAX_X: max_x_in = csr_data;
            CSR_MAX_Y: max_y_in = csr_data;
            default:   max_x_in = max_x_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_x_ff <= MAX_X_RESET;
         max_y_ff <= MAX_Y_RESET;
      end else begin
         max_x_ff <= max_x_in;
         max_y_ff <= max_y_in;
      end
   end

   // Byte phase tracking and movement forming
   pmct_packet_asm u_packet_asm (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .mv_valid    (mv_valid),
      .mv_ready    (mv_ready),
      .mv          (mv)
   );

   // Position accumulate and clamp
   pmct_cursor_upd #(
      .COORD_BITS (COORD_BITS)
   ) u_cursor_upd (
      .clock        (clock),
      .reset        (reset),
      .mv_valid     (mv_valid),
      .mv_ready     (mv_ready),
      .mv           (mv),
      .max_x        (max_x_ff),
      .max_y        (max_y_ff),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_cursor_x (rsp_cursor_x),
      .rsp_cursor_y (rsp_cursor_y)
   );

   // A blocked movement beat stays put
   a_mv_hold: assert property (@(posedge clock) disable iff (reset)
      (mv_valid && !mv_ready) |=> (mv_valid && $stable(mv)))
      else $error("movement beat lost or changed while blocked");

   // A taken movement beat shows up as a result next cycle
   a_mv_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (mv_valid && mv_ready) |=> rsp_valid)
      else $error("movement beat taken without a result");

   // No movement is taken while a result is stalled
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !mv_ready)
      else $error("movement stage open over a stalled result");

endmodule

`default_nettype wire
